@@ src/smr_pkg.sv @@
// ----------------------------------------------------------------------------
// smr_pkg
// Shared widths, operation codes and record types of the summary bin merge
// reduce block.
// ----------------------------------------------------------------------------
package smr_pkg;

  // field widths
  localparam int SEQ_W = 24;
  localparam int CRD_W = 32;
  localparam int CNT_W = 32;
  localparam int VAL_W = 32;
  localparam int SUM_W = 64;
  localparam int SQ_W  = 63;
  localparam int RW_W  = 31;

  // reduction width after reset
  localparam logic [RW_W-1:0] RW_RESET = 31'd40;

  // what the back end does with a queued record
  localparam logic [1:0] OP_OPEN  = 2'd0;  // no bin open, open one from the record
  localparam logic [1:0] OP_FOLD  = 2'd1;  // fold the record into the open bin
  localparam logic [1:0] OP_FLUSH = 2'd2;  // emit the open bin, then open a new one

  // saturation limits
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [SQ_W-1:0]  SQ_MAX  = '1;
  localparam logic [SUM_W-1:0] SUM_POS_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_NEG_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // one merged bin
  typedef struct packed {
    logic [SEQ_W-1:0]        seq_id;
    logic [CRD_W-1:0]        range_start;
    logic [CRD_W-1:0]        range_end;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] min_v;
    logic signed [VAL_W-1:0] max_v;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sumsq;
  } bin_t;

  // classified record as it waits in the queue
  typedef struct packed {
    logic [1:0] op;
    logic       last;
    bin_t       bin;
  } item_t;

endpackage

@@ src/smr_ifs.sv @@
// ----------------------------------------------------------------------------
// smr channel interfaces
// Valid/ready channels for input records, merged results and the
// reduction width register.
// ----------------------------------------------------------------------------
interface smr_in_if;
  import smr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [SEQ_W-1:0]        seq_id;
  logic [CRD_W-1:0]        range_start;
  logic [CRD_W-1:0]        range_end;
  logic [CNT_W-1:0]        count_in;
  logic signed [VAL_W-1:0] min_in;
  logic signed [VAL_W-1:0] max_in;
  logic signed [SUM_W-1:0] sum_in;
  logic [SQ_W-1:0]         sumsq_in;
  logic                    end_of_list;

  modport source (
    output valid, seq_id, range_start, range_end, count_in, min_in, max_in,
           sum_in, sumsq_in, end_of_list,
    input  ready
  );
  modport sink (
    input  valid, seq_id, range_start, range_end, count_in, min_in, max_in,
           sum_in, sumsq_in, end_of_list,
    output ready
  );
endinterface

interface smr_out_if;
  import smr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [SEQ_W-1:0]        out_seq_id;
  logic [CRD_W-1:0]        out_start;
  logic [CRD_W-1:0]        out_end;
  logic [CNT_W-1:0]        out_count;
  logic signed [VAL_W-1:0] out_min;
  logic signed [VAL_W-1:0] out_max;
  logic signed [SUM_W-1:0] out_sum;
  logic [SQ_W-1:0]         out_sumsq;
  logic                    final_of_run;

  modport source (
    output valid, out_seq_id, out_start, out_end, out_count, out_min, out_max,
           out_sum, out_sumsq, final_of_run,
    input  ready
  );
  modport sink (
    input  valid, out_seq_id, out_start, out_end, out_count, out_min, out_max,
           out_sum, out_sumsq, final_of_run,
    output ready
  );
endinterface

interface smr_cfg_if;
  import smr_pkg::*;

  logic            valid;
  logic            ready;
  logic [RW_W-1:0] reduction_width;

  modport source (output valid, reduction_width, input ready);
  modport sink (input valid, reduction_width, output ready);
endinterface

@@ src/smr_front.sv @@
// ----------------------------------------------------------------------------
// smr_front
// Accepts input beats, holds the reduction width and a shadow of the open
// bin key, and classifies each record as open, fold or flush.
// ----------------------------------------------------------------------------
module smr_front (
  input  logic           clk,
  input  logic           rst_n,
  smr_in_if.sink         in_bus,
  smr_cfg_if.sink        cfg_bus,
  input  logic           q_full,
  output logic           push,
  output smr_pkg::item_t push_item
);
  import smr_pkg::*;

  logic [RW_W-1:0]  rw_r;
  logic             open_valid_r, open_valid_nxt;
  logic [SEQ_W-1:0] open_seq_r, open_seq_nxt;
  logic [CRD_W-1:0] open_start_r, open_start_nxt;
  logic [CRD_W:0]   bound;
  logic             beyond;
  logic [1:0]       op;

  // register write port never stalls
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rw_r <= RW_RESET;
    end else if (cfg_bus.valid) begin
      rw_r <= cfg_bus.reduction_width;
    end
  end

  // bin bound, one bit wider so it never wraps
  assign bound  = {1'b0, open_start_r} + {{(CRD_W+1-RW_W){1'b0}}, rw_r};
  assign beyond = {1'b0, in_bus.range_end} > bound;

  // classify the record against the open bin key
  always_comb begin
    if (!open_valid_r) begin
      op = OP_OPEN;
    end else if (in_bus.seq_id != open_seq_r || beyond) begin
      op = OP_FLUSH;
    end else begin
      op = OP_FOLD;
    end
  end

  assign in_bus.ready = !q_full;
  assign push         = in_bus.valid && !q_full;

  always_comb begin
    push_item.op              = op;
    push_item.last            = in_bus.end_of_list;
    push_item.bin.seq_id      = in_bus.seq_id;
    push_item.bin.range_start = in_bus.range_start;
    push_item.bin.range_end   = in_bus.range_end;
    push_item.bin.count       = in_bus.count_in;
    push_item.bin.min_v       = in_bus.min_in;
    push_item.bin.max_v       = in_bus.max_in;
    push_item.bin.sum         = in_bus.sum_in;
    push_item.bin.sumsq       = in_bus.sumsq_in;
  end

  // shadow key follows what the back end will hold
  always_comb begin
    open_valid_nxt = open_valid_r;
    open_seq_nxt   = open_seq_r;
    open_start_nxt = open_start_r;
    if (push) begin
      if (in_bus.end_of_list) begin
        open_valid_nxt = 1'b0;
      end else if (op != OP_FOLD) begin
        open_valid_nxt = 1'b1;
        open_seq_nxt   = in_bus.seq_id;
        open_start_nxt = in_bus.range_start;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_valid_r <= 1'b0;
      open_seq_r   <= '0;
      open_start_r <= '0;
    end else begin
      open_valid_r <= open_valid_nxt;
      open_seq_r   <= open_seq_nxt;
      open_start_r <= open_start_nxt;
    end
  end

endmodule

@@ src/smr_queue.sv @@
// ----------------------------------------------------------------------------
// smr_queue
// Short register queue of classified records between front and back end.
// ----------------------------------------------------------------------------
module smr_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  smr_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output smr_pkg::item_t head_item
);
  import smr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ src/smr_back.sv @@
// ----------------------------------------------------------------------------
// smr_back
// Holds the open bin, folds or replaces it per queued record, and drives
// merged results through an output register.
// ----------------------------------------------------------------------------
module smr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  smr_pkg::item_t head_item,
  output logic           pop,
  smr_out_if.source      out_bus
);
  import smr_pkg::*;

  bin_t             open_r;
  logic             phase_r, phase_nxt;
  logic             out_valid_r, out_valid_nxt;
  bin_t             out_bin_r;
  logic             out_fin_r;

  logic [1:0]       op_eff;
  logic             needs_out;
  logic             can_load;
  logic             go;
  bin_t             fold_bin;
  bin_t             next_bin;
  logic [CNT_W:0]   cnt_sum;
  logic [SQ_W:0]    sq_sum;
  logic [SUM_W-1:0] sum_raw;
  logic             sum_ovf;

  // second beat of a flush on the last record emits the freshly opened bin
  assign op_eff    = phase_r ? OP_OPEN : head_item.op;
  assign needs_out = head_item.last || (op_eff == OP_FLUSH);
  assign can_load  = !out_valid_r || out_bus.ready;
  assign go        = head_valid && (!needs_out || can_load);
  assign pop       = go && !((op_eff == OP_FLUSH) && head_item.last);

  // saturating fold of the record into the open bin
  assign cnt_sum = {1'b0, open_r.count} + {1'b0, head_item.bin.count};
  assign sq_sum  = {1'b0, open_r.sumsq} + {1'b0, head_item.bin.sumsq};
  assign sum_raw = open_r.sum + head_item.bin.sum;
  assign sum_ovf = (open_r.sum[SUM_W-1] == head_item.bin.sum[SUM_W-1]) &&
                   (sum_raw[SUM_W-1] != open_r.sum[SUM_W-1]);

  always_comb begin
    fold_bin           = open_r;
    fold_bin.range_end = head_item.bin.range_end;
    fold_bin.count     = cnt_sum[CNT_W] ? CNT_MAX : cnt_sum[CNT_W-1:0];
    fold_bin.sumsq     = sq_sum[SQ_W] ? SQ_MAX : sq_sum[SQ_W-1:0];
    if (sum_ovf) begin
      fold_bin.sum = open_r.sum[SUM_W-1] ? SUM_NEG_MIN : SUM_POS_MAX;
    end else begin
      fold_bin.sum = sum_raw;
    end
    if ($signed(head_item.bin.min_v) < $signed(open_r.min_v)) begin
      fold_bin.min_v = head_item.bin.min_v;
    end
    if ($signed(head_item.bin.max_v) > $signed(open_r.max_v)) begin
      fold_bin.max_v = head_item.bin.max_v;
    end
  end

  assign next_bin = (op_eff == OP_FOLD) ? fold_bin : head_item.bin;

  // open bin and flush phase
  always_comb begin
    phase_nxt = phase_r;
    if (go) begin
      phase_nxt = (op_eff == OP_FLUSH) && head_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      open_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (go) begin
        open_r <= next_bin;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (can_load) begin
      out_valid_nxt = go && needs_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && go && needs_out) begin
      if (op_eff == OP_FLUSH) begin
        out_bin_r <= open_r;
        out_fin_r <= !head_item.last;
      end else begin
        out_bin_r <= next_bin;
        out_fin_r <= 1'b1;
      end
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.out_seq_id   = out_bin_r.seq_id;
  assign out_bus.out_start    = out_bin_r.range_start;
  assign out_bus.out_end      = out_bin_r.range_end;
  assign out_bus.out_count    = out_bin_r.count;
  assign out_bus.out_min      = out_bin_r.min_v;
  assign out_bus.out_max      = out_bin_r.max_v;
  assign out_bus.out_sum      = out_bin_r.sum;
  assign out_bus.out_sumsq    = out_bin_r.sumsq;
  assign out_bus.final_of_run = out_fin_r;

endmodule

@@ src/summary_bin_merge_reduce_top.sv @@
// Path: an accepted record is written into a queue slot, and the back end then
//   loads its result into the output register, which drives the output.
// Throughput: one record per cycle unless the queue fills or the output stalls;
//   a record that yields two results holds the back end, one output register load per result.
// Reset: reduction width 40, no open bin, queue and output register empty.
// ----------------------------------------------------------------------------
// summary_bin_merge_reduce_top
// Merges a sorted stream of summary records into bins of the configured
// width, with a classifying front end and a merging back end split by a queue.
// ----------------------------------------------------------------------------
module summary_bin_merge_reduce_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  smr_in_if.sink    in_bus,
  smr_cfg_if.sink   cfg_bus,
  smr_out_if.source out_bus
);
  import smr_pkg::*;

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  head_valid;
  item_t head_item;
  logic  pop;

  // accept and classify
  smr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .cfg_bus   (cfg_bus),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue
  smr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // merge and emit
  smr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_bus    (out_bus)
  );

endmodule

@@ test/tb_summary_bin_merge_reduce_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_summary_bin_merge_reduce_top
// Streams sorted summary records into the bin merger, with random gaps on
// both sides and one long output stall. A local bin model predicts every
// merged record, and each result beat is checked field by field.
// ----------------------------------------------------------------------------
module tb_summary_bin_merge_reduce_top;
  import smr_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 10;
  localparam logic [RW_W-1:0] RW_NARROWEST = 31'd1;
  localparam logic [RW_W-1:0] RW_WIDEST    = '1;

  // one input record and one merged result
  typedef struct packed {
    bin_t b;
    logic eol;
  } record_t;

  typedef struct packed {
    bin_t b;
    logic fin;
  } merged_t;

  logic clk;
  logic rst_n;

  smr_in_if  in_if ();
  smr_cfg_if cfg_if ();
  smr_out_if out_if ();

  summary_bin_merge_reduce_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .cfg_bus (cfg_if),
    .out_bus (out_if)
  );

  record_t records_pending[$];
  merged_t bins_due[$];
  record_t in_flight;
  logic    carrying       = 1'b0;
  int      mismatch_count = 0;
  int      cycle_count    = 0;
  logic    steady         = 1'b0;
  logic    stall_arm      = 1'b0;
  logic    stall_done     = 1'b0;
  int      hold_left      = 0;

  // bin model state
  logic [RW_W-1:0] width_q  = RW_RESET;
  logic            bin_open = 1'b0;
  bin_t            open_bin = '0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void emit_open(logic fin);
    merged_t m;
    m.b   = open_bin;
    m.fin = fin;
    bins_due.push_back(m);
  endfunction

  // open, fold or flush one record, queueing the bins it closes
  function automatic void merge_record(record_t r);
    logic [63:0] bound;
    logic [32:0] cnt;
    logic [63:0] sq;
    logic [64:0] sm;
    bound = {32'd0, open_bin.range_start} + {33'd0, width_q};
    if (!bin_open) begin
      open_bin = r.b;
      bin_open = 1'b1;
    end else if (r.b.seq_id != open_bin.seq_id || {32'd0, r.b.range_end} > bound) begin
      emit_open(!r.eol);
      open_bin = r.b;
    end else begin
      cnt = {1'b0, open_bin.count} + {1'b0, r.b.count};
      sq  = {1'b0, open_bin.sumsq} + {1'b0, r.b.sumsq};
      sm  = {open_bin.sum[SUM_W-1], open_bin.sum} + {r.b.sum[SUM_W-1], r.b.sum};
      open_bin.range_end = r.b.range_end;
      open_bin.count = cnt[CNT_W] ? CNT_MAX : cnt[CNT_W-1:0];
      open_bin.sumsq = sq[SQ_W] ? SQ_MAX : sq[SQ_W-1:0];
      // signed overflow clamps to the limit of the operands' sign
      if (sm[SUM_W] != sm[SUM_W-1]) begin
        open_bin.sum = sm[SUM_W] ? SUM_NEG_MIN : SUM_POS_MAX;
      end else begin
        open_bin.sum = sm[SUM_W-1:0];
      end
      if ($signed(r.b.min_v) < $signed(open_bin.min_v)) open_bin.min_v = r.b.min_v;
      if ($signed(r.b.max_v) > $signed(open_bin.max_v)) open_bin.max_v = r.b.max_v;
    end
    if (r.eol) begin
      emit_open(1'b1);
      bin_open = 1'b0;
    end
  endfunction

  function automatic record_t make_record(logic [SEQ_W-1:0] seq, logic [CRD_W-1:0] lo,
                                          logic [CRD_W-1:0] hi, logic [CNT_W-1:0] cnt,
                                          logic [VAL_W-1:0] mn, logic [VAL_W-1:0] mx,
                                          logic [SUM_W-1:0] sm, logic [SQ_W-1:0] sq,
                                          logic eol);
    record_t r;
    r.b.seq_id      = seq;
    r.b.range_start = lo;
    r.b.range_end   = hi;
    r.b.count       = cnt;
    r.b.min_v       = mn;
    r.b.max_v       = mx;
    r.b.sum         = sm;
    r.b.sumsq       = sq;
    r.eol           = eol;
    return r;
  endfunction

  // well-formed coordinates, payload leaning toward the saturation limits now and then
  function automatic record_t shaped_record(logic [SEQ_W-1:0] seq, logic [CRD_W-1:0] lo,
                                            logic [CRD_W-1:0] hi, logic eol);
    logic [31:0]      w;
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sm;
    logic [SQ_W-1:0]  sq;
    w = $urandom;
    cnt = ($urandom_range(0, 7) == 0) ? CNT_MAX - $urandom_range(0, 1000)
                                      : $urandom_range(0, 1000);
    case ($urandom_range(0, 7))
      0:       sm = SUM_POS_MAX - $urandom_range(0, 1000);
      1:       sm = SUM_NEG_MIN + $urandom_range(0, 1000);
      default: sm = {{32{w[31]}}, w};
    endcase
    sq = ($urandom_range(0, 7) == 0) ? SQ_MAX - $urandom_range(0, 1000)
                                     : {31'd0, $urandom};
    return make_record(seq, lo, hi, cnt, $urandom, $urandom, sm, sq, eol);
  endfunction

  function automatic record_t noise_record();
    return make_record(SEQ_W'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                       {$urandom, $urandom}, SQ_W'({$urandom, $urandom}),
                       $urandom_range(0, 3) == 0);
  endfunction

  // runs of sorted records on one sequence, sized to the current bin width
  task automatic queue_runs(int n_items, int noise_pct);
    int               made;
    int               run_len;
    logic [SEQ_W-1:0] seq;
    logic [CRD_W-1:0] lo;
    logic [CRD_W-1:0] hi;
    made = 0;
    while (made < n_items) begin
      seq = ($urandom_range(0, 3) == 0) ? SEQ_W'($urandom) : SEQ_W'($urandom_range(0, 7));
      lo = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 10000);
      run_len = $urandom_range(1, 12);
      for (int k = 0; k < run_len && made < n_items; k++) begin
        if ($urandom_range(0, 99) < noise_pct) begin
          records_pending.push_back(noise_record());
        end else begin
          hi = lo + $urandom_range(0, width_q);
          records_pending.push_back(shaped_record(seq, lo, hi,
                                                  k == run_len - 1 && $urandom_range(0, 1)));
          lo = lo + $urandom_range(0, hi - lo);
        end
        made++;
      end
    end
  endtask

  // wait until every record is in and every bin is out
  task automatic drain();
    while (records_pending.size() != 0 || carrying) @(posedge clk);
    while (bins_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(logic [RW_W-1:0] w);
    @(posedge clk);
    cfg_if.valid           <= 1'b1;
    cfg_if.reduction_width <= w;
    do @(posedge clk); while (!cfg_if.ready);
    width_q = w;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // input driver: a record per beat, random gaps
  always @(posedge clk) begin : feed
    logic holding;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      holding = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        merge_record(in_flight);
        holding  = 1'b0;
        carrying = 1'b0;
      end
      if (!holding) begin
        if (records_pending.size() != 0 && (steady || $urandom_range(0, 99) >= 33)) begin
          in_flight = records_pending.pop_front();
          carrying  = 1'b1;
          in_if.valid       <= 1'b1;
          in_if.seq_id      <= in_flight.b.seq_id;
          in_if.range_start <= in_flight.b.range_start;
          in_if.range_end   <= in_flight.b.range_end;
          in_if.count_in    <= in_flight.b.count;
          in_if.min_in      <= in_flight.b.min_v;
          in_if.max_in      <= in_flight.b.max_v;
          in_if.sum_in      <= in_flight.b.sum;
          in_if.sumsq_in    <= in_flight.b.sumsq;
          in_if.end_of_list <= in_flight.eol;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // output ready: random stalls, one long hold-off when armed
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (stall_arm && !stall_done) begin
      out_if.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      stall_done   <= 1'b1;
    end else begin
      out_if.ready <= steady || ($urandom_range(0, 99) >= 33);
    end
  end

  // result monitor: compare each beat with the oldest bin due
  always @(posedge clk) begin : watch
    merged_t got;
    merged_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.b.seq_id      = out_if.out_seq_id;
      got.b.range_start = out_if.out_start;
      got.b.range_end   = out_if.out_end;
      got.b.count       = out_if.out_count;
      got.b.min_v       = out_if.out_min;
      got.b.max_v       = out_if.out_max;
      got.b.sum         = out_if.out_sum;
      got.b.sumsq       = out_if.out_sumsq;
      got.fin           = out_if.final_of_run;
      if (bins_due.size() == 0) begin
        report_mismatch($sformatf("bin with none due: seq %h start %h end %h",
                                  got.b.seq_id, got.b.range_start, got.b.range_end));
      end else begin
        want = bins_due.pop_front();
        check_field("seq_id", got.b.seq_id, want.b.seq_id);
        check_field("start", got.b.range_start, want.b.range_start);
        check_field("end", got.b.range_end, want.b.range_end);
        check_field("count", got.b.count, want.b.count);
        check_field("min", got.b.min_v, want.b.min_v);
        check_field("max", got.b.max_v, want.b.max_v);
        check_field("sum", got.b.sum, want.b.sum);
        check_field("sumsq", got.b.sumsq, want.b.sumsq);
        check_field("final_of_run", got.fin, want.fin);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_summary_bin_merge_reduce_top: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    rst_n                  = 1'b0;
    in_if.valid            = 1'b0;
    in_if.seq_id           = '0;
    in_if.range_start      = '0;
    in_if.range_end        = '0;
    in_if.count_in         = '0;
    in_if.min_in           = '0;
    in_if.max_in           = '0;
    in_if.sum_in           = '0;
    in_if.sumsq_in         = '0;
    in_if.end_of_list      = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.reduction_width = RW_RESET;
    out_if.ready           = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed, at the reset width of 40
    // open, fold at the exact bound, fold with a smaller end, count/sum/sumsq saturate
    records_pending.push_back(make_record(24'd5, 32'd0, 32'd10, 32'd10,
                                          -32'sd327680, 32'sd458752, 64'sd100, 63'd200, 1'b0));
    records_pending.push_back(make_record(24'd5, 32'd10, 32'd40, 32'hFFFF_FFF0,
                                          32'h8000_0000, 32'h7FFF_FFFF,
                                          64'h7FFF_FFFF_FFFF_FFF0, SQ_MAX - 63'd5, 1'b0));
    records_pending.push_back(make_record(24'd5, 32'd20, 32'd25, 32'h0000_FFFF,
                                          32'd0, 32'd0, 64'h100, 63'd100, 1'b0));
    // end past the bound flushes; new bin with min above max
    records_pending.push_back(make_record(24'd5, 32'd40, 32'd41, 32'd3,
                                          32'h0001_0000, 32'hFFFF_0000,
                                          SUM_NEG_MIN + 64'd5, 63'd0, 1'b0));
    // negative sum saturation
    records_pending.push_back(make_record(24'd5, 32'd41, 32'd80, 32'd7,
                                          32'h0000_8000, 32'hFFFF_8000, -64'sd100, 63'd9, 1'b0));
    // sequence change flushes, then a last record that folds
    records_pending.push_back(make_record(24'd6, 32'd0, 32'd1000, 32'd1,
                                          32'd1, 32'd2, 64'd3, 63'd4, 1'b0));
    records_pending.push_back(make_record(24'd6, 32'd10, 32'd20, 32'd5,
                                          32'd0, 32'd9, 64'd11, 63'd12, 1'b1));
    // last record with no bin open
    records_pending.push_back(make_record(24'd7, 32'd100, 32'd200, 32'd8,
                                          32'd1, 32'd1, 64'd1, 63'd1, 1'b1));
    // last record that opens a new bin: two beats out
    records_pending.push_back(make_record(24'd7, 32'd0, 32'd5, 32'd2,
                                          32'd4, 32'd6, 64'd8, 63'd10, 1'b0));
    records_pending.push_back(make_record(24'd7, 32'd50, 32'd60, 32'd3,
                                          32'd2, 32'd3, 64'd4, 63'd5, 1'b1));
    // bound formed wide: start near the top of the coordinate range still folds
    records_pending.push_back(make_record(24'hFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd1,
                                          32'd5, 32'd5, 64'd5, 63'd5, 1'b0));
    records_pending.push_back(make_record(24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1,
                                          32'd6, 32'd4, 64'd5, 63'd5, 1'b0));
    records_pending.push_back(make_record(24'hFF_FFFF, 32'd0, 32'd0, 32'd1,
                                          32'd7, 32'd3, 64'd5, 63'd5, 1'b0));
    records_pending.push_back(make_record(24'd0, 32'd0, 32'd0, 32'd0,
                                          32'd0, 32'd0, 64'd0, 63'd0, 1'b1));
    // all-zero bin, then all-ones count, sum and sumsq with extreme min and max folded in on the last record
    records_pending.push_back(make_record(24'd0, 32'd0, 32'd0, 32'd0,
                                          32'd0, 32'd0, 64'd0, 63'd0, 1'b0));
    records_pending.push_back(make_record(24'd0, 32'd0, 32'd40, CNT_MAX,
                                          32'h8000_0000, 32'h7FFF_FFFF, '1, SQ_MAX, 1'b1));
    drain();

    // narrowest bins
    write_width(RW_NARROWEST);
    queue_runs(100, 10);
    drain();

    // widest bins
    write_width(RW_WIDEST);
    queue_runs(100, 10);
    drain();

    // random width, with the output held off long enough to back up the input
    write_width(RW_W'($urandom_range(2, 100000)));
    queue_runs(110, 10);
    stall_arm = 1'b1;
    drain();

    // back to the reset width: a stretch with no gaps, then random gaps again
    write_width(RW_RESET);
    steady = 1'b1;
    queue_runs(60, 5);
    drain();
    steady = 1'b0;
    queue_runs(60, 10);
    drain();

    if (mismatch_count == 0) begin
      $display("tb_summary_bin_merge_reduce_top: done, clean");
    end else begin
      $display("tb_summary_bin_merge_reduce_top: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/smr_pkg.sv
src/smr_ifs.sv
src/smr_front.sv
src/smr_queue.sv
src/smr_back.sv
src/summary_bin_merge_reduce_top.sv
test/tb_summary_bin_merge_reduce_top.sv
